@@ sv/orrc_pkg.sv @@
// package for the oregonator reaction rates core
// holds register index codes, reset values, the sideband struct and saturation helper
// used by orrc_divider and oregonator_reaction_rates_core
package orrc_pkg;

    localparam logic [2:0] REG_INVERSE_EPS = 3'd0;
    localparam logic [2:0] REG_REACTION_F  = 3'd1;
    localparam logic [2:0] REG_REACTION_Q  = 3'd2;
    localparam logic [2:0] REG_CURRENT_U   = 3'd3;
    localparam logic [2:0] REG_CURRENT_V   = 3'd4;

    localparam logic [30:0] INVERSE_EPS_RESET = 31'd1677721600;
    localparam logic [30:0] REACTION_F_RESET  = 31'd50331648;
    localparam logic [30:0] REACTION_Q_RESET  = 31'd3355;

    // quotient bits produced by the divider, one per stage
    localparam int QUO_BITS = 33;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] sq;
        logic signed [31:0] fv;
        logic               fault;
        logic               neg;
    } orrc_side_t;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
        logic signed [31:0] res;
        if (x[63:31] == {33{1'b0}} || x[63:31] == {33{1'b1}})
            res = x[31:0];
        else if (x[63])
            res = 32'sh8000_0000;
        else
            res = 32'sh7fff_ffff;
        return res;
    endfunction

endpackage

@@ sv/orrc_divider.sv @@
// pipelined restoring divider, one quotient bit per stage plus an overflow check stage
// depends on orrc_pkg for the sideband struct and quotient width
module orrc_divider import orrc_pkg::*; #(
    parameter int NW = 56
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [NW-1:0]    num,
    input  logic [31:0]      den,
    input  orrc_side_t       side_in,
    output logic             out_vld,
    output logic [QUO_BITS-1:0] quo,
    output logic             ovf,
    output orrc_side_t       side_out
);

    logic                vld_reg  [QUO_BITS+1];
    logic [31:0]         rem_reg  [QUO_BITS+1];
    logic [QUO_BITS-1:0] low_reg  [QUO_BITS+1];
    logic [QUO_BITS-1:0] quo_reg  [QUO_BITS+1];
    logic [31:0]         den_reg  [QUO_BITS+1];
    logic                ovf_reg  [QUO_BITS+1];
    orrc_side_t          side_reg [QUO_BITS+1];

    logic [31:0]         rem_next [QUO_BITS+1];
    logic                bit_next [QUO_BITS+1];

    logic [31:0]         head;

    assign head = 32'(num[NW-1:QUO_BITS]);

    always_comb
    begin
        logic [32:0] r2;
        logic [32:0] diff;
        rem_next[0] = head;
        bit_next[0] = 1'b0;
        for (int k = 1; k <= QUO_BITS; k++)
        begin
            r2   = {rem_reg[k-1], low_reg[k-1][QUO_BITS-1]};
            diff = r2 - {1'b0, den_reg[k-1]};
            if (r2 >= {1'b0, den_reg[k-1]})
            begin
                rem_next[k] = diff[31:0];
                bit_next[k] = 1'b1;
            end
            else
            begin
                rem_next[k] = r2[31:0];
                bit_next[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QUO_BITS; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k <= QUO_BITS; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            low_reg[0]  <= num[QUO_BITS-1:0];
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            ovf_reg[0]  <= (head >= den);
            side_reg[0] <= side_in;
            for (int k = 1; k <= QUO_BITS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= {low_reg[k-1][QUO_BITS-2:0], 1'b0};
                quo_reg[k]  <= {quo_reg[k-1][QUO_BITS-2:0], bit_next[k]};
                den_reg[k]  <= den_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_vld  = vld_reg[QUO_BITS];
    assign quo      = quo_reg[QUO_BITS];
    assign ovf      = ovf_reg[QUO_BITS];
    assign side_out = side_reg[QUO_BITS];

endmodule

@@ sv/oregonator_reaction_rates_core.sv @@
// top level of the oregonator reaction rates core
// depends on orrc_pkg and orrc_divider
// pipeline: the input transaction passes through one input stage, 34 divider stages,
// then the product, inner, scaling and output stages
// throughput: one cell per cycle while the output is not stalled, set by the fully pipelined divider
// a stall at the output freezes the whole pipeline; nothing is lost or repeated
// reset clears all valid bits and loads the register defaults at once
module oregonator_reaction_rates_core import orrc_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] activator,
    input  logic signed [31:0] inhibitor,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] activator_rate,
    output logic signed [31:0] inhibitor_rate,
    output logic               divide_fault
);

    localparam int NW = 32 + FRAC_BITS;

    logic [30:0]        inverse_eps_reg;
    logic [30:0]        reaction_f_reg;
    logic [30:0]        reaction_q_reg;
    logic signed [31:0] current_u_reg;
    logic signed [31:0] current_v_reg;

    logic en;

    // stage 1
    logic               s1_vld_reg;
    logic signed [31:0] s1_u_reg;
    logic signed [31:0] s1_v_reg;
    logic signed [63:0] s1_uu_reg;
    logic signed [63:0] s1_fvp_reg;
    logic [31:0]        s1_num_reg;
    logic [31:0]        s1_den_reg;
    logic               s1_neg_reg;
    logic               s1_fault_reg;

    logic signed [33:0] num_wide;
    logic signed [33:0] den_wide;
    logic signed [33:0] num_abs;
    logic signed [33:0] den_abs;

    orrc_side_t         side_in;
    orrc_side_t         side_out;
    logic               div_vld;
    logic [QUO_BITS-1:0] div_quo;
    logic               div_ovf;
    logic signed [31:0] ratio;

    // product stage
    logic               p_vld_reg;
    orrc_side_t         p_side_reg;
    logic signed [63:0] p_prod_reg;

    // inner stage
    logic               i_vld_reg;
    logic signed [31:0] i_u_reg;
    logic signed [31:0] i_v_reg;
    logic               i_fault_reg;
    logic signed [31:0] i_inner_reg;
    logic signed [31:0] term;
    logic signed [31:0] inner;

    // scaling stage
    logic               e_vld_reg;
    logic signed [31:0] e_u_reg;
    logic signed [31:0] e_v_reg;
    logic               e_fault_reg;
    logic signed [63:0] e_prod_reg;

    logic               out_vld_reg;
    logic signed [31:0] du_reg;
    logic signed [31:0] dv_reg;
    logic               fault_reg;
    logic signed [31:0] scl;
    logic signed [31:0] du;
    logic signed [31:0] dv;

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_eps_reg <= INVERSE_EPS_RESET;
            reaction_f_reg  <= REACTION_F_RESET;
            reaction_q_reg  <= REACTION_Q_RESET;
            current_u_reg   <= '0;
            current_v_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_INVERSE_EPS: inverse_eps_reg <= cfg_data[30:0];
                REG_REACTION_F:  reaction_f_reg  <= cfg_data[30:0];
                REG_REACTION_Q:  reaction_q_reg  <= cfg_data[30:0];
                REG_CURRENT_U:   current_u_reg   <= cfg_data;
                REG_CURRENT_V:   current_v_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign num_wide = 34'(activator) - $signed({3'b000, reaction_q_reg});
    assign den_wide = 34'(activator) + $signed({3'b000, reaction_q_reg});
    assign num_abs  = num_wide[33] ? -num_wide : num_wide;
    assign den_abs  = den_wide[33] ? -den_wide : den_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            p_vld_reg   <= 1'b0;
            i_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= in_valid;
            p_vld_reg   <= div_vld;
            i_vld_reg   <= p_vld_reg;
            e_vld_reg   <= i_vld_reg;
            out_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_u_reg     <= activator;
            s1_v_reg     <= inhibitor;
            s1_uu_reg    <= activator * activator;
            s1_fvp_reg   <= $signed({1'b0, reaction_f_reg}) * inhibitor;
            s1_num_reg   <= num_abs[31:0];
            s1_den_reg   <= den_abs[31:0];
            s1_neg_reg   <= num_wide[33] ^ den_wide[33];
            s1_fault_reg <= (den_wide == '0);
        end
    end

    always_comb
    begin
        side_in.u     = s1_u_reg;
        side_in.v     = s1_v_reg;
        side_in.sq    = sat64(s1_uu_reg >>> FRAC_BITS);
        side_in.fv    = sat64(s1_fvp_reg >>> FRAC_BITS);
        side_in.fault = s1_fault_reg;
        side_in.neg   = s1_neg_reg;
    end

    orrc_divider #(
        .NW (NW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s1_vld_reg),
        .num      ({s1_num_reg, {FRAC_BITS{1'b0}}}),
        .den      (s1_den_reg),
        .side_in  (side_in),
        .out_vld  (div_vld),
        .quo      (div_quo),
        .ovf      (div_ovf),
        .side_out (side_out)
    );

    // truncated quotient with saturation
    always_comb
    begin
        if (!side_out.neg)
        begin
            if (div_ovf || div_quo[QUO_BITS-1:31] != '0)
                ratio = 32'sh7fff_ffff;
            else
                ratio = $signed(div_quo[31:0]);
        end
        else
        begin
            if (div_ovf || div_quo[QUO_BITS-1] || (div_quo[31] && div_quo[30:0] != '0))
                ratio = 32'sh8000_0000;
            else
                ratio = -$signed(div_quo[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_side_reg <= side_out;
            p_prod_reg <= side_out.fv * ratio;
        end
    end

    assign term  = sat64(p_prod_reg >>> FRAC_BITS);
    assign inner = sat64(64'(p_side_reg.u) - 64'(p_side_reg.sq) - 64'(term));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_u_reg     <= p_side_reg.u;
            i_v_reg     <= p_side_reg.v;
            i_fault_reg <= p_side_reg.fault;
            i_inner_reg <= inner;
            e_u_reg     <= i_u_reg;
            e_v_reg     <= i_v_reg;
            e_fault_reg <= i_fault_reg;
            e_prod_reg  <= i_inner_reg * $signed({1'b0, inverse_eps_reg});
        end
    end

    assign scl = sat64(e_prod_reg >>> FRAC_BITS);
    assign du  = sat64(64'(scl) + 64'(current_u_reg));
    assign dv  = sat64(64'(e_u_reg) - 64'(e_v_reg) + 64'(current_v_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            du_reg    <= e_fault_reg ? 32'sd0 : du;
            dv_reg    <= dv;
            fault_reg <= e_fault_reg;
        end
    end

    assign out_valid      = out_vld_reg;
    assign activator_rate = du_reg;
    assign inhibitor_rate = dv_reg;
    assign divide_fault   = fault_reg;

`ifndef SYNTHESIS
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_fault |-> activator_rate == 32'sd0)
        else $error("fault result with nonzero activator rate");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_vld_reg || out_ready))
        else $error("input ready does not follow output stall");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && !en |=> s1_vld_reg && $stable(s1_u_reg))
        else $error("first stage lost data during stall");
`endif

endmodule
